### rtl/ccp_pkg.sv
`timescale 1ns / 1ps

package ccp_pkg;

  // Canvas geometry
  localparam int MAX_SIDE = 256;
  localparam int SIDE_W   = $clog2(MAX_SIDE);
  localparam int USE_W    = SIDE_W + 1;
  localparam int ADDR_W   = 2 * SIDE_W;

  // Fixed point
  localparam int FRAC_BITS = 8;
  localparam int FIXED_ONE = 1 << FRAC_BITS;
  localparam int COORD_W   = 20;
  localparam int POS_W     = SIDE_W + FRAC_BITS + 1;
  localparam int DIFF_W    = ((POS_W > COORD_W) ? POS_W : COORD_W) + 1;
  localparam int MAG_W     = DIFF_W;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int D2_W      = SQ_W + 1;
  localparam int R_SQ_W    = 2 * COORD_W;

  // Port field widths
  localparam int SIZE_W  = 9;
  localparam int BYTE_W  = 8;
  localparam int CELL_W  = 8;
  localparam int CIDX_W  = 2;
  localparam int CFG_W   = 9;

  // Configuration register indexes
  localparam logic [CIDX_W-1:0] CFG_WIDTH      = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_HEIGHT     = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_BACKGROUND = 2'd2;

  // Status codes
  localparam logic STATUS_DONE   = 1'b0;
  localparam logic STATUS_REJECT = 1'b1;

  typedef enum logic [1:0] {
    MODE_CLEAR,
    MODE_OUTLINE,
    MODE_FILLED,
    MODE_READ
  } mode_t;

  typedef struct packed {
    logic                      clear;
    logic                      filled;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic        [COORD_W-1:0] r;
    logic        [BYTE_W-1:0]  color;
    logic        [USE_W-1:0]   w;
    logic        [USE_W-1:0]   h;
  } sweep_job_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [BYTE_W-1:0] data;
  } canvas_wr_t;

  // Clamp a size register to the canvas side
  function automatic logic [USE_W-1:0] side_in_use(input logic [SIZE_W-1:0] v);
    logic [USE_W-1:0] res;
    if (int'(v) > MAX_SIDE) begin
      res = USE_W'(MAX_SIDE);
    end else begin
      res = USE_W'(v);
    end
    return res;
  endfunction

endpackage

### rtl/circle_canvas_painter_top.sv
`timescale 1ns / 1ps

// Byte canvas painter. A clear fills the canvas_width x canvas_height cells
// in use with the background byte; an outline or filled draw writes paint into
// every cell whose integer position lies within the circle (exact Q12.8
// compare of squared distances, outline covers r-1 < d <= r); a read returns
// one cell, or zero outside the area in use. Every word gets one result word:
// status 1 only for a draw with zero radius, pixel nonzero only for a read.
// One word is in flight at a time. A clear or draw sweeps the canvas one cell
// per cycle through a three-stage distance pipeline that writes the canvas
// RAM; its result word rises once the sweep has drained. A read passes the
// RAM's registered read port and S_READ; a rejected draw goes straight to
// the result, and a clear or draw over a zero-size area runs an empty sweep.
// The input reopens as the result word rises; while a result word waits
// under out_stall, the next word still runs and then waits for the output
// register. The canvas RAM has no reset and needs no clearing pass: issue a
// clear before the first read.
// Configuration writes are taken while no word is in progress.

module circle_canvas_painter_top
  import ccp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic        [COORD_W-1:0] radius,
  input  logic [BYTE_W-1:0]         paint,
  input  logic [CELL_W-1:0]         read_col,
  input  logic [CELL_W-1:0]         read_row,

  output logic                      out_valid,
  input  logic                      out_stall,
  output logic                      status,
  output logic [BYTE_W-1:0]         pixel,

  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CIDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]          cfg_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SWEEP,
    S_READ,
    S_DONE
  } state_t;

  state_t state;

  // Configuration registers
  logic [SIZE_W-1:0] canvas_width;
  logic [SIZE_W-1:0] canvas_height;
  logic [BYTE_W-1:0] background;
  logic [USE_W-1:0]  w_use;
  logic [USE_W-1:0]  h_use;

  // Result held until the output register is free
  logic              res_status;
  logic [BYTE_W-1:0] res_pixel;

  logic              in_accept;
  logic              out_free;
  logic              is_draw;
  logic              zero_radius;
  logic              read_in_area;

  logic              start;
  sweep_job_t        job;
  canvas_wr_t        wr;
  logic              busy;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic [BYTE_W-1:0] rd_data;

  assign in_stall  = state != S_IDLE;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign cfg_ready = state == S_IDLE;

  assign w_use = side_in_use(canvas_width);
  assign h_use = side_in_use(canvas_height);

  assign is_draw      = (mode_t'(mode) == MODE_OUTLINE) || (mode_t'(mode) == MODE_FILLED);
  assign zero_radius  = radius == '0;
  assign read_in_area = (USE_W'(read_col) < w_use) && (USE_W'(read_row) < h_use);

  // Kick the sweep for a clear or an accepted draw
  assign start = in_accept && ((mode_t'(mode) == MODE_CLEAR) || (is_draw && !zero_radius));

  assign job.clear  = mode_t'(mode) == MODE_CLEAR;
  assign job.filled = mode_t'(mode) == MODE_FILLED;
  assign job.cx     = center_x;
  assign job.cy     = center_y;
  assign job.r      = radius;
  assign job.color  = (mode_t'(mode) == MODE_CLEAR) ? background : paint;
  assign job.w      = w_use;
  assign job.h      = h_use;

  // Reads never overlap sweep writes: a read is taken only once the sweep
  // has drained, so no forwarding path is needed.
  assign rd_en   = in_accept && (mode_t'(mode) == MODE_READ) && read_in_area;
  assign rd_addr = {SIDE_W'(read_row), SIDE_W'(read_col)};

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width  <= SIZE_W'(256);
      canvas_height <= SIZE_W'(256);
      background    <= BYTE_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_WIDTH:      canvas_width  <= cfg_data;
        CFG_HEIGHT:     canvas_height <= cfg_data;
        CFG_BACKGROUND: background    <= cfg_data[BYTE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      status     <= STATUS_DONE;
      pixel      <= '0;
      res_status <= STATUS_DONE;
      res_pixel  <= '0;
    end else begin
      // Drop a taken result word; S_DONE refills the register itself
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_accept) begin
            res_status <= (is_draw && zero_radius) ? STATUS_REJECT : STATUS_DONE;
            res_pixel  <= '0;
            case (mode_t'(mode))
              MODE_CLEAR: begin
                state <= S_SWEEP;
              end
              MODE_OUTLINE, MODE_FILLED: begin
                if (zero_radius) begin
                  state <= S_DONE;
                end else begin
                  state <= S_SWEEP;
                end
              end
              MODE_READ: begin
                state <= read_in_area ? S_READ : S_DONE;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_SWEEP: begin
          if (!busy) begin
            state <= S_DONE;
          end
        end
        S_READ: begin
          res_pixel <= rd_data;
          state     <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            out_valid <= 1'b1;
            status    <= res_status;
            pixel     <= res_pixel;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  ccp_sweep u_sweep (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .job   (job),
    .wr    (wr),
    .busy  (busy)
  );

  ccp_canvas u_canvas (
    .clk     (clk),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

### rtl/ccp_canvas.sv
`timescale 1ns / 1ps

module ccp_canvas
  import ccp_pkg::*;
(
  input  logic              clk,
  input  canvas_wr_t        wr,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [1 << ADDR_W];

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/ccp_sweep.sv
`timescale 1ns / 1ps

module ccp_sweep
  import ccp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  sweep_job_t job,
  output canvas_wr_t wr,
  output logic       busy
);

  sweep_job_t        job_q;
  logic              scan;
  logic [SIDE_W-1:0] col;
  logic [SIDE_W-1:0] row;
  logic              col_last;
  logic              row_last;

  logic              v1;
  logic              v2;
  logic [MAG_W-1:0]  absx;
  logic [MAG_W-1:0]  absy;
  logic [ADDR_W-1:0] addr1;
  logic [SQ_W-1:0]   sqx;
  logic [SQ_W-1:0]   sqy;
  logic [ADDR_W-1:0] addr2;

  logic [R_SQ_W-1:0]  outer_q;
  logic [R_SQ_W-1:0]  inner_q;
  logic               inner_open_q;
  logic [COORD_W-1:0] inner_r;
  logic               inner_open;

  logic [DIFF_W-1:0]        pos_x;
  logic [DIFF_W-1:0]        pos_y;
  logic signed [DIFF_W-1:0] dx;
  logic signed [DIFF_W-1:0] dy;
  logic [D2_W-1:0]          d2;
  logic                     in_disk;
  logic                     ring;
  logic                     hit;

  assign col_last = USE_W'(col) == (job_q.w - USE_W'(1));
  assign row_last = USE_W'(row) == (job_q.h - USE_W'(1));

  // Scan flag and stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      scan <= 1'b0;
      v1   <= 1'b0;
      v2   <= 1'b0;
    end else begin
      v1 <= scan;
      v2 <= v1;
      if (start) begin
        scan <= (job.w != '0) && (job.h != '0);
      end else if (scan && col_last && row_last) begin
        scan <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      job_q <= job;
      col   <= '0;
      row   <= '0;
    end else if (scan) begin
      if (col_last) begin
        col <= '0;
        row <= row + SIDE_W'(1);
      end else begin
        col <= col + SIDE_W'(1);
      end
    end
  end

  // Radius squares, ready before the first compare
  assign inner_r    = job_q.r - COORD_W'(FIXED_ONE);
  assign inner_open = job_q.r < COORD_W'(FIXED_ONE);

  always_ff @(posedge clk) begin
    outer_q      <= job_q.r * job_q.r;
    inner_q      <= inner_open ? '0 : inner_r * inner_r;
    inner_open_q <= inner_open;
  end

  // Stage 1: offsets from the center, magnitude
  assign pos_x = DIFF_W'(col) << FRAC_BITS;
  assign pos_y = DIFF_W'(row) << FRAC_BITS;
  assign dx    = $signed(pos_x) - DIFF_W'(job_q.cx);
  assign dy    = $signed(pos_y) - DIFF_W'(job_q.cy);

  always_ff @(posedge clk) begin
    absx  <= dx[DIFF_W-1] ? MAG_W'(-dx) : MAG_W'(dx);
    absy  <= dy[DIFF_W-1] ? MAG_W'(-dy) : MAG_W'(dy);
    addr1 <= {row, col};
  end

  // Stage 2: squares
  always_ff @(posedge clk) begin
    sqx   <= absx * absx;
    sqy   <= absy * absy;
    addr2 <= addr1;
  end

  // Coverage test and write
  assign d2      = D2_W'(sqx) + D2_W'(sqy);
  assign in_disk = d2 <= D2_W'(outer_q);
  assign ring    = inner_open_q || (d2 > D2_W'(inner_q));
  assign hit     = job_q.clear || (in_disk && (job_q.filled || ring));

  assign wr.en   = v2 && hit;
  assign wr.addr = addr2;
  assign wr.data = job_q.color;

  assign busy = scan || v1 || v2;

endmodule

### rtl/ccp_checker.sv
`timescale 1ns / 1ps

module ccp_checker
  import ccp_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic              status,
  input logic [BYTE_W-1:0] pixel,
  input logic              cfg_ready
);

  // One word in flight: an accepted word closes the input next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input accepted back to back");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(pixel))
    else $error("stalled result changed");

  // A rejected draw carries no pixel
  a_reject_pixel: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_REJECT |-> pixel == '0)
    else $error("reject with nonzero pixel");

  // Reset leaves the block idle and empty
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall && cfg_ready)
    else $error("block not idle after reset");

endmodule

bind circle_canvas_painter_top ccp_checker u_ccp_checker (.*);

### bench/circle_canvas_checker.sv
`timescale 1ns / 1ps

module circle_canvas_checker
  import ccp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,

  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic [1:0]                mode,
  input  logic signed [COORD_W-1:0] center_x,
  input  logic signed [COORD_W-1:0] center_y,
  input  logic        [COORD_W-1:0] radius,
  input  logic [BYTE_W-1:0]         paint,
  input  logic [CELL_W-1:0]         read_col,
  input  logic [CELL_W-1:0]         read_row,

  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic                      status,
  input  logic [BYTE_W-1:0]         pixel,

  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [CIDX_W-1:0]         cfg_index,
  input  logic [CFG_W-1:0]          cfg_data,

  output int                        pending,
  output int                        errors
);

  typedef struct packed {
    logic              status;
    logic [BYTE_W-1:0] pixel;
  } answer_t;

  logic [BYTE_W-1:0] canvas_copy [MAX_SIDE*MAX_SIDE];
  logic [SIZE_W-1:0] cols_reg;
  logic [SIZE_W-1:0] rows_reg;
  logic [BYTE_W-1:0] backdrop;
  answer_t           awaited_answers [$];
  int                fail_count;

  function automatic int clip_side(input logic [SIZE_W-1:0] v);
    return (int'(v) > MAX_SIDE) ? MAX_SIDE : int'(v);
  endfunction

  // Exact squared-distance test in Q12.8; outline keeps r-1 < d <= r
  task automatic cover_circle(input longint cx, input longint cy, input longint r,
                              input bit filled, input logic [BYTE_W-1:0] color);
    longint outer_sq;
    longint inner_sq;
    longint dx;
    longint dy;
    longint d_sq;
    bit     inner_open;
    int     w;
    int     h;
    w          = clip_side(cols_reg);
    h          = clip_side(rows_reg);
    outer_sq   = r * r;
    inner_open = (r < FIXED_ONE);
    inner_sq   = (r - FIXED_ONE) * (r - FIXED_ONE);
    for (int row = 0; row < h; row++) begin
      dy = longint'(row) * FIXED_ONE - cy;
      for (int col = 0; col < w; col++) begin
        dx   = longint'(col) * FIXED_ONE - cx;
        d_sq = dx * dx + dy * dy;
        if (d_sq <= outer_sq && (filled || inner_open || d_sq > inner_sq)) begin
          canvas_copy[row * MAX_SIDE + col] = color;
        end
      end
    end
  endtask

  // Apply one accepted word to the canvas copy and return its answer
  task automatic canvas_answer(output answer_t ans);
    mode_t m;
    int    w;
    int    h;
    m          = mode_t'(mode);
    w          = clip_side(cols_reg);
    h          = clip_side(rows_reg);
    ans.status = STATUS_DONE;
    ans.pixel  = '0;
    case (m)
      MODE_CLEAR: begin
        for (int row = 0; row < h; row++) begin
          for (int col = 0; col < w; col++) begin
            canvas_copy[row * MAX_SIDE + col] = backdrop;
          end
        end
      end
      MODE_OUTLINE, MODE_FILLED: begin
        if (radius == '0) begin
          ans.status = STATUS_REJECT;
        end else begin
          cover_circle(longint'(center_x), longint'(center_y), longint'(radius),
                       m == MODE_FILLED, paint);
        end
      end
      default: begin
        if (int'(read_col) < w && int'(read_row) < h) begin
          ans.pixel = canvas_copy[int'(read_row) * MAX_SIDE + int'(read_col)];
        end
      end
    endcase
  endtask

  always @(posedge clk) begin : watch
    answer_t fresh;
    answer_t want;
    if (rst) begin
      cols_reg   = SIZE_W'(MAX_SIDE);
      rows_reg   = SIZE_W'(MAX_SIDE);
      backdrop   = BYTE_W'(32);
      fail_count = 0;
      awaited_answers.delete();
      pending <= 0;
      errors  <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_WIDTH:      cols_reg = cfg_data;
          CFG_HEIGHT:     rows_reg = cfg_data;
          CFG_BACKGROUND: backdrop = cfg_data[BYTE_W-1:0];
          default:        ;
        endcase
      end
      if (in_valid && !in_stall) begin
        canvas_answer(fresh);
        awaited_answers.push_back(fresh);
      end
      if (out_valid && !out_stall) begin
        if (awaited_answers.size() == 0) begin
          $display("%0t: result word with nothing awaited: status %0d pixel %0d",
                   $time, status, pixel);
          fail_count++;
        end else begin
          want = awaited_answers.pop_front();
          if (status !== want.status) begin
            $display("%0t: status mismatch: expected %0d actual %0d",
                     $time, want.status, status);
            fail_count++;
          end
          if (pixel !== want.pixel) begin
            $display("%0t: pixel mismatch: expected %0d actual %0d",
                     $time, want.pixel, pixel);
            fail_count++;
          end
        end
      end
      pending <= awaited_answers.size();
      errors  <= fail_count;
    end
  end

endmodule

### bench/tb_circle_canvas_painter_top.sv
`timescale 1ns / 1ps

module tb_circle_canvas_painter_top;
  import ccp_pkg::*;

  // Cycles the receiver holds off once, to back the block up into its input;
  // longer than the slowest sweep the random phases can produce
  localparam int LONG_HOLD = 8000;

  logic                      clk;
  logic                      rst;

  logic                      in_valid;
  logic                      in_stall;
  logic [1:0]                mode;
  logic signed [COORD_W-1:0] center_x;
  logic signed [COORD_W-1:0] center_y;
  logic        [COORD_W-1:0] radius;
  logic [BYTE_W-1:0]         paint;
  logic [CELL_W-1:0]         read_col;
  logic [CELL_W-1:0]         read_row;

  logic                      out_valid;
  logic                      out_stall;
  logic                      status;
  logic [BYTE_W-1:0]         pixel;

  logic                      cfg_valid;
  logic                      cfg_ready;
  logic [CIDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]          cfg_data;

  int                        pending;
  int                        errors;

  // Sender pacing and the area in use, tracked to aim reads and circles
  int                        burst_left;
  int                        cols_used;
  int                        rows_used;
  int                        random_items;
  bit                        hold_req;

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  circle_canvas_painter_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .paint    (paint),
    .read_col (read_col),
    .read_row (read_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .pixel    (pixel),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  circle_canvas_checker u_check (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .mode     (mode),
    .center_x (center_x),
    .center_y (center_y),
    .radius   (radius),
    .paint    (paint),
    .read_col (read_col),
    .read_row (read_row),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status   (status),
    .pixel    (pixel),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .pending  (pending),
    .errors   (errors)
  );

  // Offer one word and hold it until accepted. Valid stays up between words
  // of a burst; at the end of a burst drop it for a random gap.
  task automatic send_word(input mode_t m,
                           input logic signed [COORD_W-1:0] cx,
                           input logic signed [COORD_W-1:0] cy,
                           input logic [COORD_W-1:0] r,
                           input logic [BYTE_W-1:0] p,
                           input logic [CELL_W-1:0] col,
                           input logic [CELL_W-1:0] row);
    in_valid <= 1'b1;
    mode     <= m;
    center_x <= cx;
    center_y <= cy;
    radius   <= r;
    paint    <= p;
    read_col <= col;
    read_row <= row;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      // Mostly short bursts, now and then a long run with no gaps at all
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 25)
                                               : $urandom_range(0, 5);
    end
  endtask

  // Fields a word does not use still get random values, to toggle every bit
  task automatic read_cell(input int col, input int row);
    send_word(MODE_READ, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              BYTE_W'($urandom), CELL_W'(col), CELL_W'(row));
  endtask

  task automatic clear_canvas();
    send_word(MODE_CLEAR, COORD_W'($urandom), COORD_W'($urandom), COORD_W'($urandom),
              BYTE_W'($urandom), CELL_W'($urandom), CELL_W'($urandom));
  endtask

  task automatic draw(input mode_t m, input logic signed [COORD_W-1:0] cx,
                      input logic signed [COORD_W-1:0] cy, input logic [COORD_W-1:0] r,
                      input logic [BYTE_W-1:0] p);
    send_word(m, cx, cy, r, p, CELL_W'($urandom), CELL_W'($urandom));
  endtask

  // Drop valid and wait until every awaited result word has come back
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Write all three registers back to back while the block is idle
  task automatic set_canvas(input int w, input int h, input int bg);
    logic [CIDX_W-1:0] reg_idx [3];
    int                reg_val [3];
    reg_idx = '{CFG_WIDTH, CFG_HEIGHT, CFG_BACKGROUND};
    reg_val = '{w, h, bg};
    settle();
    cfg_valid <= 1'b1;
    for (int k = 0; k < 3; k++) begin
      cfg_index <= reg_idx[k];
      cfg_data  <= CFG_W'(reg_val[k]);
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid <= 1'b0;
    cols_used = (w > MAX_SIDE) ? MAX_SIDE : w;
    rows_used = (h > MAX_SIDE) ? MAX_SIDE : h;
  endtask

  // One random word: mostly circles near the area and reads inside it,
  // the rest full-range noise and clears
  task automatic random_word();
    int                        pick;
    int                        span;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic        [COORD_W-1:0] r;
    pick = $urandom_range(0, 9);
    span = ((cols_used > rows_used) ? cols_used : rows_used) + 1;
    if (pick < 4) begin
      // Center within two cells of the area, any fraction; radius up to the span
      cx = COORD_W'(int'($urandom_range(0, (cols_used + 4) * FIXED_ONE)) - 2 * FIXED_ONE);
      cy = COORD_W'(int'($urandom_range(0, (rows_used + 4) * FIXED_ONE)) - 2 * FIXED_ONE);
      r  = COORD_W'($urandom_range(1, span * FIXED_ONE));
      draw((pick % 2 == 0) ? MODE_OUTLINE : MODE_FILLED, cx, cy, r, BYTE_W'($urandom));
    end else if (pick < 8) begin
      if (cols_used > 0 && rows_used > 0) begin
        read_cell($urandom_range(0, cols_used - 1), $urandom_range(0, rows_used - 1));
      end else begin
        read_cell($urandom_range(0, 255), $urandom_range(0, 255));
      end
    end else if (pick == 8) begin
      r = ($urandom_range(0, 7) == 0) ? '0 : COORD_W'($urandom);
      draw(($urandom_range(0, 1) == 0) ? MODE_OUTLINE : MODE_FILLED,
           COORD_W'($urandom), COORD_W'($urandom), r, BYTE_W'($urandom));
    end else if ($urandom_range(0, 1) == 0) begin
      clear_canvas();
    end else begin
      read_cell($urandom_range(0, 255), $urandom_range(0, 255));
    end
  endtask

  // Receiver: stall on segments of its own, with one long hold on request
  initial begin : receiver
    int seg_len;
    int style;
    bit hold_served;
    out_stall   = 1'b0;
    hold_served = 1'b0;
    forever begin
      seg_len = $urandom_range(4, 40);
      style   = $urandom_range(0, 3);
      repeat (seg_len) begin
        @(posedge clk);
        if (hold_req && !hold_served) begin
          hold_served = 1'b1;
          out_stall <= 1'b1;
          repeat (LONG_HOLD) @(posedge clk);
        end
        case (style)
          0:       out_stall <= 1'b0;
          1:       out_stall <= 1'($urandom_range(0, 1));
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= 1'b1;
        endcase
      end
    end
  end

  initial begin : stimulus
    int w;
    int h;
    int n;
    int phase;
    rst          = 1'b1;
    in_valid     = 1'b0;
    mode         = MODE_CLEAR;
    center_x     = '0;
    center_y     = '0;
    radius       = '0;
    paint        = '0;
    read_col     = '0;
    read_row     = '0;
    cfg_valid    = 1'b0;
    cfg_index    = CFG_WIDTH;
    cfg_data     = '0;
    hold_req     = 1'b0;
    burst_left   = 0;
    cols_used    = MAX_SIDE;
    rows_used    = MAX_SIDE;
    random_items = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Full canvas at reset sizes. The clear writes every cell, so from here
    // on no read can land on a cell that was never written.
    clear_canvas();
    read_cell(0, 0);
    read_cell(255, 255);
    draw(MODE_FILLED, 20'sd32896, 20'sd25664, 20'd15360, 8'hFF);
    draw(MODE_OUTLINE, -20'sd2560, 20'sd76800, 20'd51392, 8'h00);
    // Zero radius: rejected, canvas left alone
    draw(MODE_OUTLINE, 20'sd1024, 20'sd1024, 20'd0, 8'h77);
    draw(MODE_FILLED, 20'sd1024, 20'sd1024, 20'd0, 8'h77);
    read_cell(128, 100);
    read_cell(200, 37);

    // Small area, backdrop zero
    set_canvas(16, 12, 0);
    clear_canvas();
    // Radius below one cell: the outline has no inner bound
    draw(MODE_OUTLINE, 20'sd768, 20'sd1024, 20'd128, 8'h11);
    // Extreme centers with the largest radius
    draw(MODE_FILLED, 20'h80000, 20'h80000, 20'hFFFFF, 8'h55);
    draw(MODE_OUTLINE, 20'h7FFFF, 20'h7FFFF, 20'hFFFFF, 8'hAA);
    draw(MODE_OUTLINE, 20'sd2048, 20'sd1536, 20'd1280, 8'h3C);
    read_cell(8, 1);
    read_cell(15, 11);
    // Reads just outside the area in use answer zero
    read_cell(16, 0);
    read_cell(0, 12);

    // Oversized width acts as the full side
    set_canvas(511, 1, 255);
    clear_canvas();
    read_cell(255, 0);
    read_cell(0, 1);

    // Zero-size area: clear and draw touch nothing
    set_canvas(0, 0, 0);
    clear_canvas();
    draw(MODE_FILLED, 20'sd0, 20'sd0, 20'd2560, 8'hEE);
    read_cell(0, 0);

    // Random phases: new sizes, usually a fresh clear, then a run of words.
    // Sizes stay small; an oversized side comes only with a short other side.
    phase = 0;
    while (random_items < 80) begin
      n = $urandom_range(0, 9);
      w = (n == 0) ? 0 : (n == 1) ? $urandom_range(256, 511) : $urandom_range(1, 24);
      n = $urandom_range(0, 9);
      if (w > 24) begin
        h = $urandom_range(0, 2);
      end else begin
        h = (n == 0) ? 0 : (n == 1) ? $urandom_range(256, 511) : $urandom_range(1, 24);
      end
      set_canvas(w, h, $urandom_range(0, 255));
      // Back up the block once: long receiver hold while words keep coming
      if (phase == 1) begin
        hold_req <= 1'b1;
      end
      // Skip the clear now and then, so old contents carry across sizes
      if ($urandom_range(0, 4) != 0) begin
        clear_canvas();
        random_items++;
      end
      n = $urandom_range(6, 14);
      repeat (n) begin
        random_word();
        random_items++;
      end
      phase++;
    end

    settle();
    repeat (16) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Hard stop far beyond the slowest correct run
  initial begin : watchdog
    #100_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

### circle_canvas_painter_top.f
rtl/ccp_pkg.sv
rtl/ccp_canvas.sv
rtl/ccp_sweep.sv
rtl/circle_canvas_painter_top.sv
rtl/ccp_checker.sv
bench/circle_canvas_checker.sv
bench/tb_circle_canvas_painter_top.sv
